// ===== hdl/label_expiry_date_check_core_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the label expiry check block
// ---------------------------------------------------------------------------
`ifndef LABEL_EXPIRY_DATE_CHECK_CORE_MACROS_SVH
`define LABEL_EXPIRY_DATE_CHECK_CORE_MACROS_SVH

// Check a property on every clock edge outside reset
`define LEDC_CHECK(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("ledc check failed");

// Check that a condition leads to a consequence in the next cycle
`define LEDC_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ledc next-cycle check failed");

`endif

// ===== hdl/ledc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ledc_pkg
// Types, codes and calendar helpers shared by the label expiry check.
// ---------------------------------------------------------------------------
package ledc_pkg;

    localparam int TOTAL_W     = 14;
    localparam int YEAR_STEPS  = 24;
    localparam int MONTH_STEPS = 11;

    localparam logic [1:0] ST_GOOD   = 2'd0;
    localparam logic [1:0] ST_OLD    = 2'd1;
    localparam logic [1:0] ST_PARITY = 2'd2;
    localparam logic [1:0] ST_BADDAY = 2'd3;

    localparam logic [1:0] CFG_DAY   = 2'd0;
    localparam logic [1:0] CFG_MONTH = 2'd1;
    localparam logic [1:0] CFG_YEAR  = 2'd2;

    localparam logic [3:0] DECEMBER = 4'd12;
    localparam logic [3:0] FEBRUARY = 4'd2;

    typedef struct packed {
        logic [1:0]         status;
        logic [4:0]         made_day;
        logic [3:0]         made_month;
        logic [11:0]        made_year;
        logic [TOTAL_W-1:0] total;
        logic [11:0]        year;
        logic [8:0]         yr400;    // year mod 400
        logic [3:0]         month;
        logic               done;
    } t_item;

    function automatic logic is_leap(input logic [8:0] r);
        return (r[1:0] == 2'd0) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
    endfunction

    function automatic logic [8:0] inc400(input logic [8:0] r);
        return (r == 9'd399) ? 9'd0 : r + 9'd1;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] days_before(input logic [3:0] m, input logic leap);
        logic [8:0] c;
        unique case (m)
            4'd2:    c = 9'd31;
            4'd3:    c = 9'd59;
            4'd4:    c = 9'd90;
            4'd5:    c = 9'd120;
            4'd6:    c = 9'd151;
            4'd7:    c = 9'd181;
            4'd8:    c = 9'd212;
            4'd9:    c = 9'd243;
            4'd10:   c = 9'd273;
            4'd11:   c = 9'd304;
            4'd12:   c = 9'd334;
            default: c = 9'd0;
        endcase
        return c + {8'd0, (leap && (m > FEBRUARY))};
    endfunction

endpackage
`default_nettype wire

// ===== hdl/label_expiry_date_check_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// label_expiry_date_check_core
// Label word decode, calendar check and expiry age test.
// ---------------------------------------------------------------------------
// Usage:
//   Drive i_label_word with i_start high; the item is taken at that edge.
//   o_busy is always low: a new item may enter in every cycle.
//   Each result appears for one cycle with o_valid high, in the order the
//   items came in. The pipeline has one decode stage, 24 year stages that
//   each take at most one year off the day count, 11 month stages, and one
//   output stage holding the comparison with today's date.
//   Today's date is written through i_cfg_we / i_cfg_idx / i_cfg_data
//   (0 day, 1 month, 2 year) while no item is in flight.
//   Reset clears all stage valid bits, drops items in flight and restores
//   today's date to 1 November 2023. The receiver cannot stall.
// ---------------------------------------------------------------------------
`include "label_expiry_date_check_core_macros.svh"

module label_expiry_date_check_core
    import ledc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [31:0] i_label_word,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [11:0] i_cfg_data,
    output logic             o_valid,
    output logic [1:0]       o_status,
    output logic [4:0]       o_made_day,
    output logic [3:0]       o_made_month,
    output logic [11:0]      o_made_year,
    output logic [4:0]       o_expiry_day,
    output logic [3:0]       o_expiry_month,
    output logic [11:0]      o_expiry_year
);

    localparam int NSTAGE  = YEAR_STEPS + MONTH_STEPS;
    localparam int LATENCY = NSTAGE + 2;

    logic [4:0]  r_cur_day;
    logic [3:0]  r_cur_month;
    logic [11:0] r_cur_year;

    // decode stage
    logic [4:0]  dec_day;
    logic [3:0]  dec_month;
    logic [8:0]  dec_off;
    logic [12:0] dec_shelf;
    logic [9:0]  dec_mod;
    logic        dec_leap;
    logic        dec_ok;
    t_item       n_dec;

    logic        pv [NSTAGE+1];
    t_item       pi [NSTAGE+1];

    always_comb begin
        dec_day   = i_label_word[4:0];
        dec_month = i_label_word[8:5];
        dec_off   = i_label_word[17:9];
        dec_shelf = i_label_word[30:18];
        dec_mod   = 10'd300 + {1'b0, dec_off};
        if (dec_mod >= 10'd800) begin
            dec_mod = dec_mod - 10'd800;
        end else if (dec_mod >= 10'd400) begin
            dec_mod = dec_mod - 10'd400;
        end
        dec_leap  = is_leap(dec_mod[8:0]);
        dec_ok    = (dec_month >= 4'd1) && (dec_month <= DECEMBER) && (dec_day >= 5'd1) &&
                    (dec_day <= month_len(dec_month, dec_leap));

        n_dec.made_day   = dec_day;
        n_dec.made_month = dec_month;
        n_dec.made_year  = 12'd1900 + {3'd0, dec_off};
        n_dec.year       = 12'd1900 + {3'd0, dec_off};
        n_dec.yr400      = dec_mod[8:0];
        n_dec.month      = 4'd1;
        n_dec.done       = 1'b0;
        n_dec.total      = {5'd0, days_before(dec_month, dec_leap)} +
                           {{(TOTAL_W-5){1'b0}}, dec_day} + {1'b0, dec_shelf};
        priority if (^i_label_word) begin
            n_dec.status = ST_PARITY;
        end else if (!dec_ok) begin
            n_dec.status = ST_BADDAY;
        end else begin
            n_dec.status = ST_GOOD;
        end
    end

    logic  r_dec_valid;
    t_item r_dec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dec_valid <= 1'b0;
            r_cur_day   <= 5'd1;
            r_cur_month <= 4'd11;
            r_cur_year  <= 12'd2023;
        end else begin
            r_dec_valid <= i_start;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_DAY:   r_cur_day   <= i_cfg_data[4:0];
                    CFG_MONTH: r_cur_month <= i_cfg_data[3:0];
                    CFG_YEAR:  r_cur_year  <= i_cfg_data;
                    default:   ;
                endcase
            end
        end
        r_dec <= n_dec;
    end

    assign pv[0] = r_dec_valid;
    assign pi[0] = r_dec;

    genvar g;
    generate
        for (g = 0; g < YEAR_STEPS; g++) begin : g_year
            ledc_year_step u_year (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (pv[g]),
                .i_item  (pi[g]),
                .o_valid (pv[g+1]),
                .o_item  (pi[g+1])
            );
        end
        for (g = YEAR_STEPS; g < NSTAGE; g++) begin : g_month
            ledc_month_step u_month (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (pv[g]),
                .i_item  (pi[g]),
                .o_valid (pv[g+1]),
                .o_item  (pi[g+1])
            );
        end
    endgenerate

    // age check and output register
    t_item       fin;
    logic        fin_old;
    logic        fin_ok;
    logic        r_valid;
    logic [1:0]  r_status;
    logic [4:0]  r_made_day;
    logic [3:0]  r_made_month;
    logic [11:0] r_made_year;
    logic [4:0]  r_exp_day;
    logic [3:0]  r_exp_month;
    logic [11:0] r_exp_year;

    always_comb begin
        fin     = pi[NSTAGE];
        fin_ok  = (fin.status == ST_GOOD);
        fin_old = (r_cur_year > fin.year) ||
                  ((r_cur_year == fin.year) &&
                   ((r_cur_month > fin.month) ||
                    ((r_cur_month == fin.month) &&
                     ({{(TOTAL_W-5){1'b0}}, r_cur_day} > fin.total))));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= pv[NSTAGE];
        end
        r_made_day   <= fin.made_day;
        r_made_month <= fin.made_month;
        r_made_year  <= fin.made_year;
        r_status     <= fin_ok ? (fin_old ? ST_OLD : ST_GOOD) : fin.status;
        r_exp_day    <= fin_ok ? fin.total[4:0] : 5'd0;
        r_exp_month  <= fin_ok ? fin.month : 4'd0;
        r_exp_year   <= fin_ok ? fin.year : 12'd0;
    end

    assign o_busy         = 1'b0;
    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_made_day     = r_made_day;
    assign o_made_month   = r_made_month;
    assign o_made_year    = r_made_year;
    assign o_expiry_day   = r_exp_day;
    assign o_expiry_month = r_exp_month;
    assign o_expiry_year  = r_exp_year;

    logic chk_bad;
    logic chk_exp_zero;
    logic chk_exp_sane;

    assign chk_bad      = (o_status == ST_PARITY) || (o_status == ST_BADDAY);
    assign chk_exp_zero = (o_expiry_day == 5'd0) && (o_expiry_month == 4'd0) &&
                          (o_expiry_year == 12'd0);
    assign chk_exp_sane = (o_expiry_month >= 4'd1) && (o_expiry_month <= DECEMBER) &&
                          (o_expiry_day >= 5'd1) && (o_expiry_year >= o_made_year);

    `LEDC_CHECK(a_latency, i_start |-> ##LATENCY o_valid)
    `LEDC_CHECK(a_bad_zero, (o_valid && chk_bad) |-> chk_exp_zero)
    `LEDC_CHECK(a_exp_sane, (o_valid && !chk_bad) |-> chk_exp_sane)
    `LEDC_CHECK_NEXT(a_cfg_year, i_cfg_we && i_cfg_idx == CFG_YEAR, r_cur_year == $past(i_cfg_data))

endmodule
`default_nettype wire

// ===== hdl/ledc_year_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ledc_year_step
// One pipeline stage: take a whole year off the day count where it fits.
// ---------------------------------------------------------------------------
module ledc_year_step
    import ledc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_item i_item,
    output logic       o_valid,
    output t_item      o_item
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic [8:0] ylen;

    always_comb begin
        n_item = i_item;
        ylen   = is_leap(i_item.yr400) ? 9'd366 : 9'd365;
        if (i_item.total > {5'd0, ylen}) begin
            n_item.total = i_item.total - {5'd0, ylen};
            n_item.year  = i_item.year + 12'd1;
            n_item.yr400 = inc400(i_item.yr400);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_item <= n_item;
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule
`default_nettype wire

// ===== hdl/ledc_month_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ledc_month_step
// One pipeline stage: advance the month while the day count exceeds it, up to December.
// ---------------------------------------------------------------------------
module ledc_month_step
    import ledc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_item i_item,
    output logic       o_valid,
    output t_item      o_item
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic [4:0] mlen;

    always_comb begin
        n_item = i_item;
        mlen   = month_len(i_item.month, is_leap(i_item.yr400));
        if (!i_item.done && (i_item.month < DECEMBER) &&
            (i_item.total > {{(TOTAL_W-5){1'b0}}, mlen})) begin
            n_item.total = i_item.total - {{(TOTAL_W-5){1'b0}}, mlen};
            n_item.month = i_item.month + 4'd1;
        end else begin
            n_item.done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_item <= n_item;
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Label expiry check testbench
// Drives label words through the block and checks each result against a
// calendar predictor kept in a small scoreboard, over several today dates.
// ---------------------------------------------------------------------------

class label_board;
    typedef struct {
        logic [1:0]  status;
        logic [4:0]  made_day;
        logic [3:0]  made_month;
        logic [11:0] made_year;
        logic [4:0]  exp_day;
        logic [3:0]  exp_month;
        logic [11:0] exp_year;
    } t_label_res;

    t_label_res pending[$];
    int         errors;
    int unsigned today_day, today_month, today_year;

    function new();
        errors      = 0;
        today_day   = 1;
        today_month = 11;
        today_year  = 2023;
    endfunction

    function bit leap_year(int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function int unsigned days_in(int unsigned m, int unsigned y);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap_year(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    function void note_label(logic [31:0] w);
        t_label_res  r;
        int unsigned d, m, y, total, i;
        bit          old;
        d = w[4:0];
        m = w[8:5];
        y = 1900 + w[17:9];
        r.made_day   = d;
        r.made_month = m;
        r.made_year  = y;
        r.exp_day    = 0;
        r.exp_month  = 0;
        r.exp_year   = 0;
        if (^w) begin
            r.status = ledc_pkg::ST_PARITY;
        end else if (m < 1 || m > 12 || d < 1 || d > days_in(m, y)) begin
            r.status = ledc_pkg::ST_BADDAY;
        end else begin
            total = d + w[30:18];
            for (i = 1; i < m; i++) total += days_in(i, y);
            while (total > (leap_year(y) ? 366 : 365)) begin
                total -= leap_year(y) ? 366 : 365;
                y++;
            end
            m = 1;
            while (m < 12 && total > days_in(m, y)) begin
                total -= days_in(m, y);
                m++;
            end
            old = (today_year > y) || (today_year == y &&
                  (today_month > m || (today_month == m && today_day > total)));
            r.status    = old ? ledc_pkg::ST_OLD : ledc_pkg::ST_GOOD;
            r.exp_day   = total;
            r.exp_month = m;
            r.exp_year  = y;
        end
        pending.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic [4:0] md, logic [3:0] mm,
                               logic [11:0] my, logic [4:0] ed, logic [3:0] em,
                               logic [11:0] ey);
        t_label_res e;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result status %0d", $time, st);
            errors++;
            return;
        end
        e = pending.pop_front();
        if ({e.status, e.made_day, e.made_month, e.made_year, e.exp_day, e.exp_month,
             e.exp_year} !== {st, md, mm, my, ed, em, ey}) begin
            $display("%0t: mismatch expected st=%0d made=%0d/%0d/%0d exp=%0d/%0d/%0d",
                     $time, e.status, e.made_day, e.made_month, e.made_year,
                     e.exp_day, e.exp_month, e.exp_year);
            $display("%0t:          actual   st=%0d made=%0d/%0d/%0d exp=%0d/%0d/%0d",
                     $time, st, md, mm, my, ed, em, ey);
            errors++;
        end
    endfunction
endclass

module testbench;
    import ledc_pkg::*;

    logic        i_clk, i_rst_n, i_start, i_cfg_we;
    logic [31:0] i_label_word;
    logic [1:0]  i_cfg_idx;
    logic [11:0] i_cfg_data;
    logic        o_busy, o_valid;
    logic [1:0]  o_status;
    logic [4:0]  o_made_day, o_expiry_day;
    logic [3:0]  o_made_month, o_expiry_month;
    logic [11:0] o_made_year, o_expiry_year;

    label_board board;
    bit         calm;

    label_expiry_date_check_core dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            board.check_result(o_status, o_made_day, o_made_month, o_made_year,
                               o_expiry_day, o_expiry_month, o_expiry_year);
    end

    // Hold the write enable high; set_today drops it after the last write
    task automatic write_today(logic [1:0] idx, logic [11:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_DAY:   board.today_day   = val[4:0];
            CFG_MONTH: board.today_month = val[3:0];
            default:   board.today_year  = val;
        endcase
    endtask

    task automatic set_today(int unsigned d, int unsigned m, int unsigned y);
        write_today(CFG_DAY, d[11:0]);
        write_today(CFG_MONTH, m[11:0]);
        write_today(CFG_YEAR, y[11:0]);
        i_cfg_we <= 1'b0;
    endtask

    // Send one item; fix parity to even unless asked to break it
    task automatic send_label(logic [31:0] w, bit fix_parity);
        if (fix_parity) w[31] = ^w[30:0];
        while (!calm && $urandom_range(99) < 12) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start      <= 1'b1;
        i_label_word <= w;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        board.note_label(w);
    endtask

    task automatic drain();
        int n;
        n = 0;
        i_start <= 1'b0;
        while (board.pending.size() != 0 && n < 1000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (40) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pack_label(int unsigned d, int unsigned m,
                                               int unsigned yoff, int unsigned shelf);
        return {1'b0, shelf[12:0], yoff[8:0], m[3:0], d[4:0]};
    endfunction

    // Mostly well-formed dates, some raw noise
    function automatic logic [31:0] random_label();
        int unsigned m, yoff;
        logic [31:0] w;
        w = $urandom;
        if ($urandom_range(9) < 8) begin
            m    = $urandom_range(12, 1);
            yoff = $urandom_range(511);
            w    = pack_label($urandom_range(board.days_in(m, 1900 + yoff), 1), m, yoff,
                              $urandom_range(3) == 0 ? $urandom_range(8191)
                                                     : $urandom_range(800));
        end
        return w;
    endfunction

    initial begin
        int          k;
        bit [31:0]   rw;
        board        = new();
        calm         = 1'b0;
        i_rst_n      = 1'b0;
        i_start      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_DAY;
        i_cfg_data   = '0;
        i_label_word = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, leap days, month edges, parity errors
        send_label(32'h0000_0000, 1'b0);
        send_label(32'hFFFF_FFFF, 1'b0);
        send_label(32'h0000_0001, 1'b0);
        send_label(pack_label(1, 1, 0, 0), 1'b1);
        send_label(pack_label(31, 12, 511, 8191), 1'b1);
        send_label(pack_label(29, 2, 100, 10), 1'b1);   // 2000 leap
        send_label(pack_label(29, 2, 0, 10), 1'b1);     // 1900 not leap
        send_label(pack_label(29, 2, 124, 365), 1'b1);  // 2024 leap
        send_label(pack_label(29, 2, 123, 1), 1'b1);    // 2023 not leap
        send_label(pack_label(1, 0, 50, 5), 1'b1);
        send_label(pack_label(1, 13, 50, 5), 1'b1);
        send_label(pack_label(1, 15, 50, 5), 1'b1);
        send_label(pack_label(0, 5, 50, 5), 1'b1);
        send_label(pack_label(31, 4, 50, 5), 1'b1);
        send_label(pack_label(31, 10, 123, 1), 1'b1);   // expiry equal to today
        send_label(pack_label(31, 10, 123, 0), 1'b1);
        send_label(pack_label(31, 12, 499, 8191), 1'b1); // crosses 2400
        send_label(pack_label(28, 2, 200, 1), 1'b1);    // 2100 not leap
        send_label(pack_label(5, 6, 77, 4000), 1'b0);
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_today(1, 1, 1900);
                1: set_today(31, 12, 4095);
                2: set_today(0, 0, 2000);
                3: set_today(31, 15, 2400);
                default: begin
                    set_today($urandom_range(31), $urandom_range(15),
                              $urandom_range(2450, 1900));
                end
            endcase
            for (k = 0; k < 310; k++) begin
                calm = (k >= 120 && k < 200);
                rw   = random_label();
                send_label(rw, $urandom_range(9) != 0);
            end
            calm = 1'b0;
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/ledc_pkg.sv
hdl/ledc_year_step.sv
hdl/ledc_month_step.sv
hdl/label_expiry_date_check_core.sv
dv/testbench.sv
